>>> design/ntrs_pkg.sv
// Shared types, constants and command codes of the neighbor table engine.
package ntrs_pkg;

   // Fixed field widths.
   localparam int IP_W      = 32;
   localparam int MAC_W     = 48;
   localparam int GEO_W     = 64;
   localparam int HEADING_W = 9;
   localparam int CMD_W     = 3;
   localparam int SLOT_W    = 6;
   localparam int CELL_W    = 2;
   localparam int INDEX_W   = 6;
   localparam int DWELL_W   = 2;
   localparam int COUNT_W   = 7;

   // Table depth default and the fixed grid geometry.
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int GRID_SIZE       = 3;
   localparam int GRID_CELLS      = GRID_SIZE * GRID_SIZE;

   // Heading boundaries in degrees.
   localparam int HEAD_EAST_LO  = 45;
   localparam int HEAD_SOUTH_LO = 135;
   localparam int HEAD_WEST_LO  = 225;
   localparam int HEAD_NORTH_LO = 315;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WRITE_ENTRY = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_CELL  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FIND_IP     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FIND_MAC    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIRST_GRID  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_BEST_GRID   = 3'd5;

   // One neighbor table entry as stored in the table memory.
   typedef struct packed {
      logic [IP_W-1:0]      ip;
      logic [MAC_W-1:0]     mac;
      logic [GEO_W-1:0]     geo;
      logic [HEADING_W-1:0] heading;
   } entry_type;

   // Grid lookup result for one probed entry.
   typedef struct packed {
      logic               hit;
      logic [DWELL_W-1:0] dwell;
   } grid_match_type;

endpackage

>>> design/ntrs_if.sv
// Request and response channel interfaces of the neighbor table engine.
interface ntrs_req_if import ntrs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [SLOT_W-1:0]    slot;
   logic [CELL_W-1:0]    cell_row;
   logic [CELL_W-1:0]    cell_col;
   logic [IP_W-1:0]      ip_addr;
   logic [MAC_W-1:0]     mac_addr;
   logic [GEO_W-1:0]     geo_code;
   logic [HEADING_W-1:0] heading;

   modport source (output valid, command, slot, cell_row, cell_col, ip_addr, mac_addr,
                   geo_code, heading, input ready);
   modport sink   (input valid, command, slot, cell_row, cell_col, ip_addr, mac_addr,
                   geo_code, heading, output ready);
endinterface

interface ntrs_rsp_if import ntrs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [INDEX_W-1:0] hit_index;
   logic [GEO_W-1:0]   hit_geo;
   logic [DWELL_W-1:0] dwell;

   modport source (output valid, found, hit_index, hit_geo, dwell, input ready);
   modport sink   (input valid, found, hit_index, hit_geo, dwell, output ready);
endinterface

>>> design/ntrs_table.sv
// Neighbor entry memory: one write port, one read port with registered data.
module ntrs_table import ntrs_pkg::*; #(
   parameter int DEPTH  = TABLE_DEPTH_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/ntrs_grid.sv
// Geohash grid cells with parallel compare and dwell evaluation of one entry.
module ntrs_grid import ntrs_pkg::*; (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [CELL_W-1:0]    wr_row,
   input  logic [CELL_W-1:0]    wr_col,
   input  logic [GEO_W-1:0]     wr_geo,
   input  logic [GEO_W-1:0]     probe_geo,
   input  logic [HEADING_W-1:0] probe_heading,
   output grid_match_type       match
);

   localparam logic [1:0] QUAD_NORTH = 2'd0;
   localparam logic [1:0] QUAD_EAST  = 2'd1;
   localparam logic [1:0] QUAD_SOUTH = 2'd2;
   localparam logic [1:0] QUAD_WEST  = 2'd3;

   logic [GEO_W-1:0]      cells_ff [GRID_CELLS];
   logic [GRID_CELLS-1:0] hit_vec;
   logic [GRID_CELLS-1:0] first_vec;
   logic [1:0]            quad;
   logic [DWELL_W-1:0]    dwell_sel;
   logic                  cell_ok;
   logic [3:0]            wr_index;

   // Cell write; out-of-range coordinates are dropped.
   assign cell_ok  = (wr_row < CELL_W'(GRID_SIZE)) && (wr_col < CELL_W'(GRID_SIZE));
   assign wr_index = 4'(wr_row) * 4'(GRID_SIZE) + 4'(wr_col);

   always_ff @(posedge clock) begin
      if (wr_en && cell_ok) begin
         cells_ff[wr_index] <= wr_geo;
      end
   end

   // Heading quadrant; headings of 315 and above count as north.
   always_comb begin
      if (probe_heading >= HEADING_W'(HEAD_EAST_LO) &&
          probe_heading <  HEADING_W'(HEAD_SOUTH_LO)) begin
         quad = QUAD_EAST;
      end else if (probe_heading >= HEADING_W'(HEAD_SOUTH_LO) &&
                   probe_heading <  HEADING_W'(HEAD_WEST_LO)) begin
         quad = QUAD_SOUTH;
      end else if (probe_heading >= HEADING_W'(HEAD_WEST_LO) &&
                   probe_heading <  HEADING_W'(HEAD_NORTH_LO)) begin
         quad = QUAD_WEST;
      end else begin
         quad = QUAD_NORTH;
      end
   end

   // Compare against all cells at once and keep the first hit in row-major order.
   always_comb begin
      for (int k = 0; k < GRID_CELLS; k++) begin
         hit_vec[k] = (probe_geo == cells_ff[k]);
      end
   end

   assign first_vec = hit_vec & ~(hit_vec - GRID_CELLS'(1));

   // Dwell of the first matching cell.
   always_comb begin
      dwell_sel = '0;
      for (int r = 0; r < GRID_SIZE; r++) begin
         for (int c = 0; c < GRID_SIZE; c++) begin
            if (first_vec[r * GRID_SIZE + c]) begin
               unique case (quad)
                  QUAD_EAST:  dwell_sel = DWELL_W'(GRID_SIZE - c);
                  QUAD_WEST:  dwell_sel = DWELL_W'(c + 1);
                  QUAD_SOUTH: dwell_sel = DWELL_W'(GRID_SIZE - r);
                  default:    dwell_sel = DWELL_W'(r + 1);
               endcase
            end
         end
      end
   end

   assign match.hit   = |hit_vec;
   assign match.dwell = dwell_sel;

endmodule

>>> design/neighbor_table_relay_select.sv
// A write or unused command passes through the response state to the response
// register; a search over n scanned entries reads them in turn, ending early on a
// hit (a full dwell for a best-grid search). One request is taken at a time; the
// scan walks the single read port of the entry memory one entry per cycle.
// Reset clears the sequencer, the response valid flag and entry_count; the entry
// memory and grid cells are not cleared and hold garbage until written.
module neighbor_table_relay_select import ntrs_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   ntrs_req_if.sink           req_chan,
   ntrs_rsp_if.source         rsp_chan,
   input  logic               csr_we,
   input  logic [COUNT_W-1:0] csr_wdata
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   // Control registers.
   logic [1:0]         state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] entry_count_ff;

   // Search context.
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [IP_W-1:0]    key_ip_ff, key_ip_in;
   logic [MAC_W-1:0]   key_mac_ff, key_mac_in;
   logic [CNT_W-1:0]   scan_len_ff, scan_len_in;
   logic [CNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [ADDR_W-1:0]  chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic [ADDR_W-1:0]  hit_idx_ff, hit_idx_in;
   logic [GEO_W-1:0]   hit_geo_ff, hit_geo_in;
   logic [DWELL_W-1:0] best_ff, best_in;

   // Response register.
   logic               rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [GEO_W-1:0]   rsp_geo_ff, rsp_geo_in;
   logic [DWELL_W-1:0] rsp_dwell_ff, rsp_dwell_in;

   logic               req_xfer;
   logic               entry_we;
   logic               cell_we;
   logic               rd_en;
   entry_type          wr_entry;
   entry_type          rd_entry;
   grid_match_type     grid_match;
   logic               is_best;
   logic               key_match;
   logic               stop_now;
   logic               take;
   logic               issue;
   logic [CNT_W-1:0]   scan_len_calc;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // Table and grid writes happen at the request transfer.
   assign entry_we = req_xfer && (req_chan.command == CMD_WRITE_ENTRY) &&
                     (32'(req_chan.slot) < TABLE_DEPTH);
   assign cell_we  = req_xfer && (req_chan.command == CMD_WRITE_CELL);

   assign wr_entry.ip      = req_chan.ip_addr;
   assign wr_entry.mac     = req_chan.mac_addr;
   assign wr_entry.geo     = req_chan.geo_code;
   assign wr_entry.heading = req_chan.heading;

   ntrs_table #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (ADDR_W'(req_chan.slot)),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   ntrs_grid u_grid (
      .clock         (clock),
      .wr_en         (cell_we),
      .wr_row        (req_chan.cell_row),
      .wr_col        (req_chan.cell_col),
      .wr_geo        (req_chan.geo_code),
      .probe_geo     (rd_entry.geo),
      .probe_heading (rd_entry.heading),
      .match         (grid_match)
   );

   // Scan length is the entry count capped at the table depth.
   always_comb begin
      if (CMP_W'(entry_count_ff) > CMP_W'(TABLE_DEPTH)) begin
         scan_len_calc = CNT_W'(TABLE_DEPTH);
      end else begin
         scan_len_calc = CNT_W'(entry_count_ff);
      end
   end

   // Evaluation of the entry whose read data has just arrived.
   assign is_best = (cmd_ff == CMD_BEST_GRID);

   always_comb begin
      case (cmd_ff)
         CMD_FIND_IP:  key_match = (rd_entry.ip == key_ip_ff);
         CMD_FIND_MAC: key_match = (rd_entry.mac == key_mac_ff);
         default:      key_match = grid_match.hit;
      endcase
   end

   assign stop_now = chk_valid_ff &&
                     (is_best ? (grid_match.dwell == DWELL_W'(GRID_SIZE)) : key_match);
   assign take     = chk_valid_ff &&
                     (is_best ? (grid_match.dwell > best_ff) : key_match);
   assign issue    = (state_ff == ST_SCAN) && !stop_now && (rd_cnt_ff < scan_len_ff);
   assign rd_en    = issue;

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_ip_in    = key_ip_ff;
      key_mac_in   = key_mac_ff;
      scan_len_in  = scan_len_ff;
      rd_cnt_in    = rd_cnt_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_geo_in   = hit_geo_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_geo_in   = rsp_geo_ff;
      rsp_dwell_in = rsp_dwell_ff;

      // A waiting result leaves on its transfer.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in      = req_chan.command;
               key_ip_in   = req_chan.ip_addr;
               key_mac_in  = req_chan.mac_addr;
               scan_len_in = scan_len_calc;
               rd_cnt_in   = '0;
               hit_in      = 1'b0;
               best_in     = '0;
               case (req_chan.command) inside
                  CMD_FIND_IP, CMD_FIND_MAC, CMD_FIRST_GRID, CMD_BEST_GRID:
                     state_in = ST_SCAN;
                  default:
                     state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN: begin
            if (take) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
               hit_geo_in = rd_entry.geo;
               best_in    = is_best ? grid_match.dwell : '0;
            end
            if (issue) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_cnt_ff[ADDR_W-1:0];
               rd_cnt_in    = rd_cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_index_in = hit_ff ? INDEX_W'(hit_idx_ff) : '0;
               rsp_geo_in   = hit_ff ? hit_geo_ff : '0;
               rsp_dwell_in = hit_ff ? best_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         chk_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_valid_ff <= chk_valid_in;
         if (csr_we) begin
            entry_count_ff <= csr_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ip_ff    <= key_ip_in;
      key_mac_ff   <= key_mac_in;
      scan_len_ff  <= scan_len_in;
      rd_cnt_ff    <= rd_cnt_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_geo_ff   <= hit_geo_in;
      best_ff      <= best_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_geo_ff   <= rsp_geo_in;
      rsp_dwell_ff <= rsp_dwell_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = rsp_found_ff;
   assign rsp_chan.hit_index = rsp_index_ff;
   assign rsp_chan.hit_geo   = rsp_geo_ff;
   assign rsp_chan.dwell     = rsp_dwell_ff;

   // A command that does not search goes straight to the response state.
   a_write_to_resp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_chan.command == CMD_WRITE_ENTRY ||
                   req_chan.command == CMD_WRITE_CELL) |=> state_ff == ST_RESP)
      else $error("write command did not go to the response state");

   // The scan never reads past its length.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> rd_cnt_ff <= scan_len_ff)
      else $error("scan read counter passed the scan length");

   // A nonzero dwell only comes with a hit.
   a_dwell_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dwell_ff != '0 |-> rsp_found_ff)
      else $error("dwell reported without a hit");

   // A search that has stopped on a full dwell must have recorded it.
   a_stop_take: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && stop_now |=> hit_ff)
      else $error("scan stopped without recording the hit");

endmodule
